@@ rtl/assert_macros.svh @@
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle (overlapping) implication checked at every clock edge outside reset.
`define CHK_IMPL(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication checked outside reset.
`define CHK_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/ptmap_pkg.sv @@
// Package with constants, types and helpers of the page table mapper.
package ptmap_pkg;

   localparam int TABLE_PAGES       = 64;
   localparam int ENTRIES_PER_TABLE = 512;
   localparam int PAGE_BITS         = (TABLE_PAGES > 1) ? $clog2(TABLE_PAGES) : 1;
   localparam int IDX_BITS          = 9;
   localparam int ADDR_BITS         = PAGE_BITS + IDX_BITS;
   localparam int PN_BITS           = 36;

   localparam logic [1:0] OP_MAP   = 2'd0;
   localparam logic [1:0] OP_QUERY = 2'd1;
   localparam logic [1:0] OP_UNMAP = 2'd2;

   localparam logic [63:0] KEEP_MASK  = 64'h7FFF_FFFF_FFFF_F000;
   localparam logic [63:0] LOW_FLAGS  = 64'h0000_0000_0000_01FF;
   localparam logic [63:0] PRESENT_RW = 64'h0000_0000_0000_0003;
   localparam logic [PN_BITS-1:0] BASE_RESET_PN = 36'h0_0001_0000;

   typedef struct packed {
      logic                 we;
      logic [ADDR_BITS-1:0] addr;
      logic [63:0]          wdata;
   } mem_req_type;

   typedef struct packed {
      logic valid;
      logic status;
      logic unmapped;
   } result_type;

   function automatic logic [IDX_BITS-1:0] level_index(input logic [47:0] va,
                                                       input logic [1:0] lvl);
      logic [IDX_BITS-1:0] r;
      case (lvl)
         2'd0: r = va[47:39];
         2'd1: r = va[38:30];
         2'd2: r = va[29:21];
         default: r = va[20:12];
      endcase
      return r;
   endfunction

endpackage

@@ rtl/ptmap_ram.sv @@
// Single-port table store with registered read.
module ptmap_ram (
   input  logic                          clock,
   input  ptmap_pkg::mem_req_type        mem_req,
   output logic [63:0]                   rdata
);

   logic [63:0] mem [ptmap_pkg::TABLE_PAGES*ptmap_pkg::ENTRIES_PER_TABLE];

   always_ff @(posedge clock) begin
      if (mem_req.we) begin
         mem[mem_req.addr] <= mem_req.wdata;
      end
      rdata <= mem[mem_req.addr];
   end

endmodule

@@ rtl/ptmap_walk.sv @@
// Walk sequencer: root table clear after reset, then map, query and unmap over the table store.
module ptmap_walk (
   input  logic                               clock,
   input  logic                               reset,
   input  logic [ptmap_pkg::PN_BITS-1:0]      base_pn,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [1:0]                         op,
   input  logic [47:0]                        va,
   input  logic [47:0]                        pa,
   input  logic [63:0]                        flags,
   output ptmap_pkg::mem_req_type             mem_req,
   input  logic [63:0]                        rdata,
   output ptmap_pkg::result_type              result,
   input  logic                               result_ready
);

   localparam int PB = ptmap_pkg::PAGE_BITS;
   localparam int NB = ptmap_pkg::PN_BITS;

   localparam logic [3:0] S_CLR    = 4'd0;
   localparam logic [3:0] S_IDLE   = 4'd1;
   localparam logic [3:0] S_RD     = 4'd2;
   localparam logic [3:0] S_EV     = 4'd3;
   localparam logic [3:0] S_ZERO   = 4'd4;
   localparam logic [3:0] S_CHK    = 4'd5;
   localparam logic [3:0] S_LEAF   = 4'd6;
   localparam logic [3:0] S_SCAN   = 4'd7;
   localparam logic [3:0] S_SCHK   = 4'd8;
   localparam logic [3:0] S_CLRENT = 4'd9;
   localparam logic [3:0] S_DONE   = 4'd10;

   localparam logic [PB:0]   PAGES_W = (PB+1)'(ptmap_pkg::TABLE_PAGES);
   localparam logic [8:0]    LAST_IDX = 9'(ptmap_pkg::ENTRIES_PER_TABLE - 1);

   logic [3:0]    state_ff, state_in;
   logic [1:0]    op_ff, op_in;
   logic [47:0]   va_ff, va_in;
   logic [47:0]   pa_ff, pa_in;
   logic [63:0]   flags_ff, flags_in;
   logic [1:0]    lvl_ff, lvl_in;
   logic [PB-1:0] pg_ff [4];
   logic [PB-1:0] pg_in [4];
   logic [PB-1:0] nfp_ff, nfp_in;
   logic [63:0]   ent_ff, ent_in;
   logic [8:0]    cnt_ff, cnt_in;
   logic          status_ff, status_in;
   logic          unm_ff, unm_in;

   logic [PB:0]   np;
   logic [NB-1:0] alloc_pn;
   logic [63:0]   alloc_ent;
   logic [63:0]   merge_ent;
   logic [NB-1:0] diff;
   logic          child_ok;
   logic [8:0]    cur_idx;
   logic [PB-1:0] up_pg;

   assign np        = {1'b0, nfp_ff} + (PB+1)'(1);
   assign alloc_pn  = base_pn + NB'(np);
   assign alloc_ent = flags_ff | {16'b0, alloc_pn, 12'b0} | ptmap_pkg::PRESENT_RW;
   assign merge_ent = (rdata & ptmap_pkg::KEEP_MASK) | (flags_ff & ptmap_pkg::LOW_FLAGS)
                      | ptmap_pkg::PRESENT_RW;
   assign diff      = ent_ff[47:12] - base_pn;
   assign child_ok  = (ent_ff[47:12] >= base_pn) && (diff[NB-1:PB] == '0)
                      && (diff[PB-1:0] <= nfp_ff);
   assign cur_idx   = ptmap_pkg::level_index(va_ff, lvl_ff);
   assign up_pg     = pg_ff[lvl_ff + 2'd1];

   assign req_ready       = (state_ff == S_IDLE);
   assign result.valid    = (state_ff == S_DONE);
   assign result.status   = status_ff;
   assign result.unmapped = unm_ff;

   always_comb begin
      state_in  = state_ff;
      op_in     = op_ff;
      va_in     = va_ff;
      pa_in     = pa_ff;
      flags_in  = flags_ff;
      lvl_in    = lvl_ff;
      pg_in     = pg_ff;
      nfp_in    = nfp_ff;
      ent_in    = ent_ff;
      cnt_in    = cnt_ff;
      status_in = status_ff;
      unm_in    = unm_ff;
      mem_req.we    = 1'b0;
      mem_req.addr  = {pg_ff[lvl_ff], cur_idx};
      mem_req.wdata = '0;
      unique case (state_ff)
         S_CLR: begin
            mem_req.we   = 1'b1;
            mem_req.addr = {PB'(0), cnt_ff};
            cnt_in       = cnt_ff + 9'd1;
            if (cnt_ff == LAST_IDX) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               op_in     = op;
               va_in     = va;
               pa_in     = pa;
               flags_in  = flags;
               lvl_in    = 2'd0;
               pg_in[0]  = '0;
               status_in = 1'b0;
               unm_in    = 1'b0;
               if (op == ptmap_pkg::OP_MAP || op == ptmap_pkg::OP_QUERY
                   || op == ptmap_pkg::OP_UNMAP) begin
                  state_in = S_RD;
               end else begin
                  state_in = S_DONE;
               end
            end
         end
         S_RD: begin
            state_in = S_EV;
         end
         S_EV: begin
            case (op_ff)
               ptmap_pkg::OP_MAP: begin
                  if (rdata == '0) begin
                     if (np >= PAGES_W) begin
                        status_in = 1'b1;
                        state_in  = S_DONE;
                     end else begin
                        nfp_in        = np[PB-1:0];
                        mem_req.we    = 1'b1;
                        mem_req.wdata = alloc_ent;
                        ent_in        = alloc_ent;
                        cnt_in        = '0;
                        state_in      = S_ZERO;
                     end
                  end else begin
                     mem_req.we    = 1'b1;
                     mem_req.wdata = merge_ent;
                     ent_in        = merge_ent;
                     state_in      = S_CHK;
                  end
               end
               ptmap_pkg::OP_QUERY: begin
                  if (!rdata[0]) begin
                     unm_in   = 1'b1;
                     state_in = S_DONE;
                  end else if (lvl_ff == 2'd3) begin
                     state_in = S_DONE;
                  end else begin
                     ent_in   = rdata;
                     state_in = S_CHK;
                  end
               end
               default: begin
                  if (!rdata[0]) begin
                     cnt_in = '0;
                     if (lvl_ff == 2'd0) begin
                        state_in = S_DONE;
                     end else begin
                        lvl_in   = lvl_ff - 2'd1;
                        state_in = S_SCAN;
                     end
                  end else if (lvl_ff == 2'd3) begin
                     mem_req.we = 1'b1;
                     lvl_in     = 2'd2;
                     cnt_in     = '0;
                     state_in   = S_SCAN;
                  end else begin
                     ent_in   = rdata;
                     state_in = S_CHK;
                  end
               end
            endcase
         end
         S_ZERO: begin
            mem_req.we   = 1'b1;
            mem_req.addr = {nfp_ff, cnt_ff};
            cnt_in       = cnt_ff + 9'd1;
            if (cnt_ff == LAST_IDX) begin
               state_in = S_CHK;
            end
         end
         S_CHK: begin
            if (!child_ok) begin
               status_in = (op_ff == ptmap_pkg::OP_MAP);
               unm_in    = (op_ff == ptmap_pkg::OP_QUERY);
               state_in  = S_DONE;
            end else begin
               pg_in[lvl_ff + 2'd1] = diff[PB-1:0];
               lvl_in               = lvl_ff + 2'd1;
               if (op_ff == ptmap_pkg::OP_MAP && lvl_ff == 2'd2) begin
                  state_in = S_LEAF;
               end else begin
                  state_in = S_RD;
               end
            end
         end
         S_LEAF: begin
            mem_req.we    = 1'b1;
            mem_req.wdata = flags_ff | {16'b0, pa_ff[47:12], 12'b0} | ptmap_pkg::PRESENT_RW;
            state_in      = S_DONE;
         end
         S_SCAN: begin
            mem_req.addr = {up_pg, cnt_ff};
            state_in     = S_SCHK;
         end
         S_SCHK: begin
            if (rdata != '0) begin
               state_in = S_DONE;
            end else if (cnt_ff == LAST_IDX) begin
               state_in = S_CLRENT;
            end else begin
               cnt_in   = cnt_ff + 9'd1;
               state_in = S_SCAN;
            end
         end
         S_CLRENT: begin
            mem_req.we = 1'b1;
            cnt_in     = '0;
            if (lvl_ff == 2'd0) begin
               state_in = S_DONE;
            end else begin
               lvl_in   = lvl_ff - 2'd1;
               state_in = S_SCAN;
            end
         end
         S_DONE: begin
            if (result_ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLR;
         cnt_ff   <= '0;
         nfp_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         nfp_ff   <= nfp_in;
      end
      op_ff     <= op_in;
      va_ff     <= va_in;
      pa_ff     <= pa_in;
      flags_ff  <= flags_in;
      lvl_ff    <= lvl_in;
      pg_ff     <= pg_in;
      ent_ff    <= ent_in;
      status_ff <= status_in;
      unm_ff    <= unm_in;
   end

endmodule

@@ rtl/four_level_page_table_mapper_unit.sv @@
// Top level of the four-level page table mapper.
//
// Channel   Direction  Handshake                 Payload
// req_      in         req_tvalid / req_tready   opcode, virt_addr, phys_addr, entry_flags
// rsp_      out        rsp_tvalid / rsp_tready   status, unmapped
// csr_      in         APB, pready always high   table_base at byte address 0
//
// After reset the root table is cleared, entry by entry, before the first request is taken.
// Each level walked passes through read, evaluate and check, and the leaf level through read
// and evaluate; the result is then handed over in the done state before returning to idle.
// A map writes the leaf without reading it, and zeroes every table it allocates, entry by entry.
// An unmap clears a present leaf and on the way back scans each child table, reading and
// checking each entry, until one is non-zero; the parent entry of an all-zero table is cleared.
// All work is paced by the single port of the table store; a result waits in the output
// register while the next request is taken.
module four_level_page_table_mapper_unit (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   // opcode[1:0], virt_addr[49:2], phys_addr[97:50], entry_flags[161:98], zero fill
   input  logic [167:0]  req_tdata,
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   // status[0], unmapped[1], zero fill
   output logic [7:0]    rsp_tdata,
   input  logic          csr_psel,
   input  logic          csr_penable,
   input  logic          csr_pwrite,
   input  logic [3:0]    csr_paddr,
   input  logic [63:0]   csr_pwdata,
   output logic [63:0]   csr_prdata,
   output logic          csr_pready
);

   logic [ptmap_pkg::PN_BITS-1:0] base_ff;
   logic                          rsp_v_ff;
   logic [1:0]                    rsp_d_ff;
   logic                          res_ready;
   ptmap_pkg::mem_req_type        mem_req;
   ptmap_pkg::result_type         result;
   logic [63:0]                   rdata;

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[3] == 1'b0) ? {16'b0, base_ff, 12'b0} : 64'b0;
   assign res_ready  = !rsp_v_ff || rsp_tready;
   assign rsp_tvalid = rsp_v_ff;
   assign rsp_tdata  = {6'b0, rsp_d_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff  <= ptmap_pkg::BASE_RESET_PN;
         rsp_v_ff <= 1'b0;
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_paddr[3] == 1'b0) begin
            base_ff <= csr_pwdata[47:12];
         end
         if (result.valid && res_ready) begin
            rsp_v_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_v_ff <= 1'b0;
         end
      end
      if (result.valid && res_ready) begin
         rsp_d_ff <= {result.unmapped, result.status};
      end
   end

   ptmap_walk u_walk (
      .clock        (clock),
      .reset        (reset),
      .base_pn      (base_ff),
      .req_valid    (req_tvalid),
      .req_ready    (req_tready),
      .op           (req_tdata[1:0]),
      .va           (req_tdata[49:2]),
      .pa           (req_tdata[97:50]),
      .flags        (req_tdata[161:98]),
      .mem_req      (mem_req),
      .rdata        (rdata),
      .result       (result),
      .result_ready (res_ready)
   );

   ptmap_ram u_ram (
      .clock   (clock),
      .mem_req (mem_req),
      .rdata   (rdata)
   );

endmodule

@@ rtl/ptmap_checker.sv @@
// Port-level checker for the page table mapper, bound to the top level.
`include "assert_macros.svh"

module ptmap_checker (
   input logic         clock,
   input logic         reset,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [7:0]   rsp_tdata,
   input logic         csr_pready
);

   `CHK_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata), "stalled response changed")
   `CHK_IMPL(a_rsp_pad, clock, reset, rsp_tvalid, rsp_tdata[7:2] == 6'b0, "response fill bits set")
   `CHK_IMPL(a_rsp_excl, clock, reset, rsp_tvalid, !(rsp_tdata[0] && rsp_tdata[1]), "status and unmapped both set")
   `CHK_IMPL(a_pready, clock, reset, 1'b1, csr_pready, "pready low")

endmodule

bind four_level_page_table_mapper_unit ptmap_checker u_ptmap_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .csr_pready (csr_pready)
);
